// File: sv/sfs_pkg.sv
// Shared types, codes and microcode store for the sprite frame sequencer.
// No dependencies; used by sfs_seq and sprite_frame_sequencer.
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 16;

  // Wide enough for a forward sum of two 32-bit values
  localparam int DIV_BITS = 33;
  localparam int DCNT_W   = 6;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_SET     = 2'd2;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] PC_LD0  = 5'd0;
  localparam logic [PC_W-1:0] PC_LD1  = 5'd1;
  localparam logic [PC_W-1:0] PC_ST0  = 5'd2;
  localparam logic [PC_W-1:0] PC_AD0  = 5'd3;
  localparam logic [PC_W-1:0] PC_AD1  = 5'd4;
  localparam logic [PC_W-1:0] PC_AD2  = 5'd5;
  localparam logic [PC_W-1:0] PC_AD3  = 5'd6;
  localparam logic [PC_W-1:0] PC_DV0  = 5'd7;
  localparam logic [PC_W-1:0] PC_DV1  = 5'd8;
  localparam logic [PC_W-1:0] PC_WSEL = 5'd9;
  localparam logic [PC_W-1:0] PC_WF0  = 5'd10;
  localparam logic [PC_W-1:0] PC_WF1  = 5'd11;
  localparam logic [PC_W-1:0] PC_WF2  = 5'd12;
  localparam logic [PC_W-1:0] PC_WB0  = 5'd13;
  localparam logic [PC_W-1:0] PC_WB1  = 5'd14;
  localparam logic [PC_W-1:0] PC_WB2  = 5'd15;
  localparam logic [PC_W-1:0] PC_ZR   = 5'd16;
  localparam logic [PC_W-1:0] PC_DONE = 5'd17;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CLEAR,
    ACT_TOTAL,
    ACT_SUM,
    ACT_CLASSIFY,
    ACT_DIV_STEP,
    ACT_FIX,
    ACT_FWD_STEP,
    ACT_BWD_STEP,
    ACT_ZERO,
    ACT_FINISH
  } act_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_TOTAL_ZERO,
    COND_NO_WRAP,
    COND_DIV_MORE,
    COND_BWD,
    COND_FWD_MORE,
    COND_BWD_MORE
  } cond_e;

  typedef enum logic [1:0] {
    ASEL_SLOT_PREV,
    ASEL_LAST,
    ASEL_FRAME,
    ASEL_FRAME_M1
  } asel_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    asel_e           asel;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic total_zero;
    logic no_wrap;
    logic div_more;
    logic bwd;
    logic fwd_more;
    logic bwd_more;
  } flags_t;

  function automatic logic [PC_W-1:0] entry_pc(logic [1:0] op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_LOAD:    pc = PC_LD0;
      OP_ADVANCE: pc = PC_AD0;
      OP_SET:     pc = PC_ST0;
      default:    pc = PC_DONE;
    endcase
    return pc;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_LD0:  w = '{ACT_NONE,     COND_NEXT,       ASEL_SLOT_PREV, PC_DONE};
      PC_LD1:  w = '{ACT_LOAD,     COND_ALWAYS,     ASEL_SLOT_PREV, PC_DONE};
      PC_ST0:  w = '{ACT_CLEAR,    COND_NEXT,       ASEL_LAST,      PC_DONE};
      PC_AD0:  w = '{ACT_NONE,     COND_NEXT,       ASEL_LAST,      PC_DONE};
      PC_AD1:  w = '{ACT_TOTAL,    COND_TOTAL_ZERO, ASEL_LAST,      PC_ZR};
      PC_AD2:  w = '{ACT_SUM,      COND_NEXT,       ASEL_LAST,      PC_DONE};
      PC_AD3:  w = '{ACT_CLASSIFY, COND_NO_WRAP,    ASEL_LAST,      PC_WSEL};
      PC_DV0:  w = '{ACT_DIV_STEP, COND_DIV_MORE,   ASEL_LAST,      PC_DV0};
      PC_DV1:  w = '{ACT_FIX,      COND_NEXT,       ASEL_LAST,      PC_DONE};
      PC_WSEL: w = '{ACT_NONE,     COND_BWD,        ASEL_FRAME,     PC_WB0};
      PC_WF0:  w = '{ACT_NONE,     COND_NEXT,       ASEL_FRAME,     PC_DONE};
      PC_WF1:  w = '{ACT_FWD_STEP, COND_FWD_MORE,   ASEL_FRAME,     PC_WF0};
      PC_WF2:  w = '{ACT_NONE,     COND_ALWAYS,     ASEL_FRAME,     PC_DONE};
      PC_WB0:  w = '{ACT_NONE,     COND_NEXT,       ASEL_FRAME_M1,  PC_DONE};
      PC_WB1:  w = '{ACT_BWD_STEP, COND_BWD_MORE,   ASEL_FRAME_M1,  PC_WB0};
      PC_WB2:  w = '{ACT_NONE,     COND_ALWAYS,     ASEL_FRAME,     PC_DONE};
      PC_ZR:   w = '{ACT_ZERO,     COND_NEXT,       ASEL_FRAME,     PC_DONE};
      PC_DONE: w = '{ACT_FINISH,   COND_NEXT,       ASEL_FRAME,     PC_DONE};
      default: w = '{ACT_NONE,     COND_ALWAYS,     ASEL_FRAME,     PC_DONE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/sprite_frame_sequencer.sv
// Looping sprite animation timer: frame end table, 16.16 time, frame walk.
// Depends on sfs_pkg, sfs_ram (end time table) and sfs_seq (microcode control).
//
//  channel | valid / ready           | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o | operation_i, frame_slot_i, amount_i
//  out     | out_valid_o/out_ready_i | frame_index_o, time_now_o, no_wrap_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_frame_count_i
//
// One item at a time: an advance reads the total, sums, classifies and walks
// the frames (a set clears first); a zero total goes straight to time 0, and a
// wrap adds a serial remainder over the 33-bit sum. The walk steps frame by
// frame through the single registered read port of the end time table. A new
// item is taken while the previous result waits in the output register; the
// last step stalls until that register is free.
// Reset gives time 0, frame 0, frame count 1.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  frame_slot_i,
  input  logic signed [31:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  frame_index_o,
  output logic [31:0] time_now_o,
  output logic        no_wrap_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_frame_count_i
);

  localparam int FW = $clog2(MAX_FRAMES);

  logic [4:0]    frame_count_q;
  logic [31:0]   time_q;
  logic [FW-1:0] frame_q;
  logic [3:0]    slot_q;
  logic [31:0]   amount_q;
  logic [31:0]   total_q;
  logic [33:0]   acc_q;
  logic [sfs_pkg::DIV_BITS-1:0] div_q;
  logic [31:0]   rem_q;
  logic [sfs_pkg::DCNT_W-1:0] cnt_q;
  logic          kept_q;
  logic          out_valid_q;

  logic            in_acc;
  logic            out_free;
  logic            busy;
  logic            finish;
  sfs_pkg::uword_t uw;
  sfs_pkg::flags_t flags;

  logic [FW-1:0] last;
  logic [FW-1:0] raddr;
  logic [31:0]   rdata;
  logic          we;
  logic [31:0]   wdata;
  logic          slot_ok;
  logic          bwd;
  logic [32:0]   load_sum;
  logic [32:0]   trial;
  logic [33:0]   acc_neg;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = !busy;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign bwd         = amount_q[31];

  // frame count 0 acts as 1, above the table size as the table size
  always_comb begin
    if (frame_count_q == 5'd0) begin
      last = '0;
    end else if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
      last = FW'(MAX_FRAMES - 1);
    end else begin
      last = FW'(frame_count_q - 5'd1);
    end
  end

  always_comb begin
    unique case (uw.asel)
      sfs_pkg::ASEL_SLOT_PREV: raddr = FW'(slot_q - 4'd1);
      sfs_pkg::ASEL_LAST:      raddr = last;
      sfs_pkg::ASEL_FRAME:     raddr = frame_q;
      sfs_pkg::ASEL_FRAME_M1:  raddr = frame_q - 1'b1;
      default:                 raddr = frame_q;
    endcase
  end

  // load: previous end time plus non-negative duration, saturated
  assign slot_ok  = 32'(slot_q) < 32'(MAX_FRAMES);
  assign load_sum = {1'b0, ((slot_q == 4'd0) ? 32'd0 : rdata)}
                  + {1'b0, (amount_q[31] ? 32'd0 : amount_q)};
  assign wdata    = load_sum[32] ? 32'hFFFF_FFFF : load_sum[31:0];
  assign we       = busy && (uw.act == sfs_pkg::ACT_LOAD) && slot_ok;

  assign trial   = {rem_q, div_q[sfs_pkg::DIV_BITS-1]};
  assign acc_neg = 34'd0 - acc_q;

  always_comb begin
    flags.total_zero = (rdata == 32'd0);
    flags.no_wrap    = bwd ? !acc_q[33] : (acc_q[32:0] < {1'b0, total_q});
    flags.div_more   = (cnt_q != '0);
    flags.bwd        = bwd;
    flags.fwd_more   = (frame_q < last) && (time_q >= rdata);
    flags.bwd_more   = (frame_q != '0) && (time_q < rdata);
  end

  sfs_ram #(
    .WIDTH (32),
    .DEPTH (MAX_FRAMES)
  ) u_end_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (FW'(slot_q)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sfs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .op_i       (operation_i),
    .flags_i    (flags),
    .out_free_i (out_free),
    .uword_o    (uw),
    .busy_o     (busy),
    .finish_o   (finish)
  );

  // item payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q   <= frame_slot_i;
      amount_q <= amount_i;
    end
    if (busy) begin
      case (uw.act)
        sfs_pkg::ACT_TOTAL: total_q <= rdata;
        sfs_pkg::ACT_SUM:   acc_q   <= {2'b00, time_q} + {{2{amount_q[31]}}, amount_q};
        sfs_pkg::ACT_CLASSIFY: begin
          div_q <= bwd ? acc_neg[sfs_pkg::DIV_BITS-1:0] : acc_q[sfs_pkg::DIV_BITS-1:0];
          rem_q <= '0;
          cnt_q <= sfs_pkg::DCNT_W'(sfs_pkg::DIV_BITS - 1);
        end
        sfs_pkg::ACT_DIV_STEP: begin
          rem_q <= (trial >= {1'b0, total_q}) ? 32'(trial - {1'b0, total_q})
                                              : trial[31:0];
          div_q <= div_q << 1;
          cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
    if (finish) begin
      frame_index_o <= 4'(frame_q);
      time_now_o    <= time_q;
      no_wrap_o     <= kept_q;
    end
  end

  // animation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= 5'd1;
      time_q        <= '0;
      frame_q       <= '0;
      kept_q        <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        kept_q <= 1'b1;
      end
      if (busy) begin
        case (uw.act) inside
          sfs_pkg::ACT_LOAD, sfs_pkg::ACT_CLEAR: begin
            time_q  <= '0;
            frame_q <= '0;
          end
          sfs_pkg::ACT_ZERO: begin
            time_q  <= '0;
            frame_q <= '0;
            kept_q  <= 1'b1;
          end
          sfs_pkg::ACT_CLASSIFY: begin
            if (flags.no_wrap) begin
              time_q <= acc_q[31:0];
            end else begin
              kept_q  <= 1'b0;
              frame_q <= bwd ? last : '0;
            end
          end
          sfs_pkg::ACT_FIX: begin
            if (!bwd) begin
              time_q <= rem_q;
            end else begin
              time_q <= (rem_q == 32'd0) ? 32'd0 : total_q - rem_q;
            end
          end
          sfs_pkg::ACT_FWD_STEP: begin
            if (flags.fwd_more) begin
              frame_q <= frame_q + 1'b1;
            end
          end
          sfs_pkg::ACT_BWD_STEP: begin
            if (flags.bwd_more) begin
              frame_q <= frame_q - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // restart on a frame count write
      if (cfg_valid_i && cfg_ready_o) begin
        frame_count_q <= cfg_frame_count_i;
        time_q        <= '0;
        frame_q       <= '0;
      end
    end
  end

  // an accepted item occupies the sequencer on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy)
    else $error("sequencer not busy after item accept");

  // a completed program leaves a result in the output register and goes idle
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_o && !busy))
    else $error("finish did not load output register");

  // a blocked last step keeps the item in flight instead of dropping it
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && (uw.act == sfs_pkg::ACT_FINISH) && out_valid_o && !out_ready_i)
      |=> (busy && (uw.act == sfs_pkg::ACT_FINISH)))
    else $error("result lost while output stalled");

  // the remainder loop never runs past its step count
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && (uw.act == sfs_pkg::ACT_DIV_STEP) && (cnt_q == '0))
      |=> (uw.act == sfs_pkg::ACT_FIX))
    else $error("remainder loop overran");

endmodule

// File: sv/sfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/sfs_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on sfs_pkg (control word, flags, program).
module sfs_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  op_i,
  input  sfs_pkg::flags_t             flags_i,
  input  logic                        out_free_i,
  output sfs_pkg::uword_t             uword_o,
  output logic                        busy_o,
  output logic                        finish_o
);

  logic [sfs_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     busy_q, busy_d;
  logic                     take;

  assign uword_o  = sfs_pkg::ucode(pc_q);
  assign busy_o   = busy_q;
  assign finish_o = busy_q && (uword_o.act == sfs_pkg::ACT_FINISH) && out_free_i;

  always_comb begin
    unique case (uword_o.cond)
      sfs_pkg::COND_NEXT:       take = 1'b0;
      sfs_pkg::COND_ALWAYS:     take = 1'b1;
      sfs_pkg::COND_TOTAL_ZERO: take = flags_i.total_zero;
      sfs_pkg::COND_NO_WRAP:    take = flags_i.no_wrap;
      sfs_pkg::COND_DIV_MORE:   take = flags_i.div_more;
      sfs_pkg::COND_BWD:        take = flags_i.bwd;
      sfs_pkg::COND_FWD_MORE:   take = flags_i.fwd_more;
      sfs_pkg::COND_BWD_MORE:   take = flags_i.bwd_more;
      default:                  take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        pc_d   = sfs_pkg::entry_pc(op_i);
        busy_d = 1'b1;
      end
    end else if (uword_o.act == sfs_pkg::ACT_FINISH) begin
      // hold on the last step until the output register is free
      if (out_free_i) begin
        busy_d = 1'b0;
      end
    end else if (take) begin
      pc_d = uword_o.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= sfs_pkg::PC_DONE;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule
